FILE: hdl/macl_pkg.sv
`timescale 1ns / 1ps

package macl_pkg;

  // Table geometry.
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Field widths fixed by the interface.
  localparam int unsigned LIST_W = 10;
  localparam int unsigned MAC_W = 48;
  localparam int unsigned SLOT_W = 6;

  // Operation codes.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Input word.
  typedef struct packed {
    logic              operation;
    logic [LIST_W-1:0] list_id;
    logic [MAC_W-1:0]  mac_addr;
    logic [SLOT_W-1:0] entry_index;
    logic [MAC_W-1:0]  entry_address;
    logic [MAC_W-1:0]  entry_wildcard;
    logic              entry_grant;
    logic              entry_valid;
  } macl_req_t;

  // Result word.
  typedef struct packed {
    logic              permit;
    logic              list_present;
    logic              matched;
    logic [SLOT_W-1:0] match_index;
  } macl_rsp_t;

  // One table slot as held in the entry memory.
  typedef struct packed {
    logic [LIST_W-1:0] list_id;
    logic [MAC_W-1:0]  address;
    logic [MAC_W-1:0]  mask;
    logic              grant;
  } macl_entry_t;

  localparam int unsigned ENTRY_W = $bits(macl_entry_t);

endpackage

FILE: hdl/macl_ram.sv
`timescale 1ns / 1ps

module macl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/mac_acl_first_match_unit.sv
`timescale 1ns / 1ps
// Channel   Ports                         Direction  Handshake
// request   req_i, start_i, busy_o        in         word taken when start_i & !busy_o
// result    rsp_o, result_valid_o         out        word taken while result_valid_o is high
//
// A write word stores its slot at acceptance and returns an all-zero result
// in the next cycle; busy_o stays low, so words may follow back to back.
// A lookup word scans the entry memory one slot per cycle through its single
// read port, ending early on the first matching slot. busy_o is high during
// the scan.
// Reset clears the used flags of all slots at once; slot contents need no reset.
// The receiver cannot stall: each result is shown for exactly one cycle.

module mac_acl_first_match_unit
  import macl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  macl_req_t req_i,
  output logic      result_valid_o,
  output macl_rsp_t rsp_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic state_q, state_d;
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;
  logic present_q, present_d;
  logic [LIST_W-1:0] list_q, list_d;
  logic [MAC_W-1:0] mac_q, mac_d;
  logic result_valid_q, result_valid_d;
  macl_rsp_t rsp_q, rsp_d;
  logic [TABLE_ENTRIES-1:0] used_q, used_d;

  logic accept;
  logic is_write;
  logic slot_in_range;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  macl_entry_t wentry;
  macl_entry_t rentry;
  logic [ENTRY_W-1:0] rdata;
  logic cur_in_list;
  logic cur_hit;
  logic cur_present;

  assign accept = start_i && !busy_o;
  assign is_write = (req_i.operation == OP_WRITE);
  assign slot_in_range = ({26'b0, req_i.entry_index} < 32'(TABLE_ENTRIES));
  assign waddr = IDX_W'(req_i.entry_index);

  // Slot image for a write word.
  always_comb begin
    wentry.list_id = req_i.list_id;
    wentry.address = req_i.entry_address;
    wentry.mask = req_i.entry_wildcard;
    wentry.grant = req_i.entry_grant;
  end

  // Read address: slot zero on acceptance, then one ahead of the checked slot.
  assign raddr = (state_q == ST_SCAN) ? (chk_idx_q + 1'b1) : '0;

  macl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (accept && is_write && slot_in_range),
    .waddr_i(waddr),
    .wdata_i(wentry),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rentry = macl_entry_t'(rdata);

  // Shared compare unit: checks the slot that the memory returns this cycle.
  assign cur_in_list = used_q[chk_idx_q] && (rentry.list_id == list_q);
  assign cur_hit = cur_in_list && (rentry.address == (mac_q & ~rentry.mask));
  assign cur_present = present_q || cur_in_list;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    chk_idx_d = chk_idx_q;
    present_d = present_q;
    list_d = list_q;
    mac_d = mac_q;
    used_d = used_q;
    result_valid_d = 1'b0;
    rsp_d = rsp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_write) begin
            if (slot_in_range) begin
              used_d[waddr] = req_i.entry_valid;
            end
            result_valid_d = 1'b1;
            rsp_d = '0;
          end else begin
            list_d = req_i.list_id;
            mac_d = req_i.mac_addr;
            chk_idx_d = '0;
            present_d = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        present_d = cur_present;
        chk_idx_d = chk_idx_q + 1'b1;
        if (cur_hit || (chk_idx_q == LAST_IDX)) begin
          state_d = ST_IDLE;
          result_valid_d = 1'b1;
          rsp_d.list_present = cur_present;
          rsp_d.matched = cur_hit;
          rsp_d.match_index = cur_hit ? SLOT_W'(chk_idx_q) : '0;
          if (cur_hit) begin
            rsp_d.permit = rentry.grant;
          end else begin
            rsp_d.permit = !cur_present;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      result_valid_q <= result_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    present_q <= present_d;
    list_q <= list_d;
    mac_q <= mac_d;
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q == ST_SCAN);
  assign result_valid_o = result_valid_q;
  assign rsp_o = rsp_q;

`ifndef SYNTHESIS
  // The end of a scan always delivers a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o)
    else $error("scan ended without a result");

  // A write word returns an all-zero result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.operation == OP_WRITE)
      |=> (result_valid_o && rsp_o == '0))
    else $error("write result missing or not zero");

  // A match implies the list has a used slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.matched) |-> rsp_o.list_present)
    else $error("match reported for an empty list");

  // No result is shown while a scan is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !result_valid_o)
    else $error("result strobe during scan");
`endif

endmodule
